FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is true.
`define ASSERT_IMPL(label, clk, rst, a, c) \
    label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while rst is true.
`define ASSERT_NEXT(label, clk, rst, a, c) \
    label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: design/fsfd_pkg.sv
// Types, constants and the CRC-8 step function for the flow sensor frame decoder.
// No dependencies.
package fsfd_pkg;

    localparam int FRAME_BYTES = 9;
    localparam int POS_W       = 4;

    // byte positions inside one frame
    localparam logic [POS_W-1:0] POS_FLOW_HI   = 4'd0;
    localparam logic [POS_W-1:0] POS_FLOW_LO   = 4'd1;
    localparam logic [POS_W-1:0] POS_FLOW_CRC  = 4'd2;
    localparam logic [POS_W-1:0] POS_TEMP_HI   = 4'd3;
    localparam logic [POS_W-1:0] POS_TEMP_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_STAT_HI   = 4'd6;
    localparam logic [POS_W-1:0] POS_STAT_LO   = 4'd7;
    localparam logic [POS_W-1:0] POS_LAST      = 4'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    localparam int FLOW_W = 20;
    localparam int TEMP_W = 19;
    localparam int WORD_W = 16;

    // flow scaling: (raw + 24576) * 100 / 17, divide done by reciprocal
    localparam int               SUM_W       = 18;
    localparam logic [SUM_W-1:0] FLOW_OFFSET = 18'd24576;
    localparam int               MAG_W       = 23;
    localparam logic [MAG_W-1:0] FLOW_SCALE  = 23'd100;
    localparam logic [MAG_W-1:0] DIV_RECIP   = 23'd7895161;  // ceil(2^27 / 17)
    localparam int               DIV_SHIFT   = 27;
    localparam int               PROD_W      = 2 * MAG_W;

    // APB register map
    localparam int   PADDR_W       = 3;
    localparam logic REG_CRC_CHECK = 1'b0;

    typedef struct packed {
        logic [WORD_W-1:0] flow_word;
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] status_word;
        logic              crc_good;
    } t_frame;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: design/flow_sensor_frame_decoder_top.sv
// Flow sensor frame decoder: one byte per cycle, one result per nine-byte frame.
// Each frame's record passes the queue, then the 4-stage scaling pipe, before it is valid.
// Throughput: one byte and one scaled record per cycle while the output is not stalled.
// Input ready drops only when the frame queue is full behind a stalled output.
// Synchronous active-low reset clears position, CRC, queue and pipe valids; CRC check on.
// Depends on fsfd_pkg, fsfd_front, fsfd_queue, fsfd_back.
module flow_sensor_frame_decoder_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_frame_start,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [fsfd_pkg::FLOW_W-1:0]  o_flow_milli,
    output logic signed [fsfd_pkg::TEMP_W-1:0]  o_temp_milli,
    output logic signed [fsfd_pkg::WORD_W-1:0]  o_status_word,
    output logic                                o_crc_good,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [fsfd_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic               r_crc_check_enable;
    logic               cfg_wr;
    logic               push, pop, q_empty, q_full;
    fsfd_pkg::t_frame   front_frame, head_frame;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[2] == fsfd_pkg::REG_CRC_CHECK);
    assign prdata = (paddr[2] == fsfd_pkg::REG_CRC_CHECK) ? {31'b0, r_crc_check_enable}
                                                          : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc_check_enable <= 1'b1;
        end else if (cfg_wr) begin
            r_crc_check_enable <= pwdata[0];
        end
    end

    fsfd_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_frame_start      (i_frame_start),
        .i_data_byte        (i_data_byte),
        .i_crc_check_enable (r_crc_check_enable),
        .i_queue_full       (q_full),
        .o_push             (push),
        .o_frame            (front_frame)
    );

    fsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_frame (front_frame),
        .i_pop   (pop),
        .o_frame (head_frame),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    fsfd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (head_frame),
        .i_frame_valid (!q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_flow_milli  (o_flow_milli),
        .o_temp_milli  (o_temp_milli),
        .o_status_word (o_status_word),
        .o_crc_good    (o_crc_good)
    );

endmodule

FILE: design/fsfd_front.sv
// Front end: takes bytes, tracks frame position, runs the flow CRC, assembles words.
// Pushes one t_frame record per complete frame. Uses fsfd_pkg.
module fsfd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_frame_start,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_crc_check_enable,
    input  logic                  i_queue_full,
    output logic                  o_push,
    output fsfd_pkg::t_frame      o_frame
);

    logic [fsfd_pkg::POS_W-1:0]  r_pos, n_pos, pos;
    logic [15:0]                 r_flow, n_flow;
    logic [15:0]                 r_temp, n_temp;
    logic [7:0]                  r_stat_hi, n_stat_hi;
    logic [15:0]                 r_status, n_status;
    logic [7:0]                  r_crc, n_crc;
    logic                        r_matched, n_matched;
    logic                        accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        pos = (i_frame_start || (r_pos >= fsfd_pkg::POS_W'(fsfd_pkg::FRAME_BYTES)))
              ? fsfd_pkg::POS_FLOW_HI : r_pos;
        n_pos     = r_pos;
        n_flow    = r_flow;
        n_temp    = r_temp;
        n_stat_hi = r_stat_hi;
        n_status  = r_status;
        n_crc     = r_crc;
        n_matched = r_matched;
        if (accept) begin
            case (pos)
                fsfd_pkg::POS_FLOW_HI: begin
                    n_flow    = {i_data_byte, 8'h00};
                    n_crc     = fsfd_pkg::crc8_byte(fsfd_pkg::CRC_INIT, i_data_byte);
                    n_matched = 1'b0;
                end
                fsfd_pkg::POS_FLOW_LO: begin
                    n_flow = {r_flow[15:8], i_data_byte};
                    n_crc  = fsfd_pkg::crc8_byte(r_crc, i_data_byte);
                end
                fsfd_pkg::POS_FLOW_CRC: n_matched = (r_crc == i_data_byte);
                fsfd_pkg::POS_TEMP_HI:  n_temp    = {i_data_byte, 8'h00};
                fsfd_pkg::POS_TEMP_LO:  n_temp    = {r_temp[15:8], i_data_byte};
                fsfd_pkg::POS_STAT_HI:  n_stat_hi = i_data_byte;
                fsfd_pkg::POS_STAT_LO:  n_status  = {r_stat_hi, i_data_byte};
                default: ;
            endcase
            n_pos = (pos == fsfd_pkg::POS_LAST) ? fsfd_pkg::POS_FLOW_HI
                                                : pos + fsfd_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_flow    <= '0;
            r_temp    <= '0;
            r_stat_hi <= '0;
            r_status  <= '0;
            r_crc     <= fsfd_pkg::CRC_INIT;
            r_matched <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_flow    <= n_flow;
            r_temp    <= n_temp;
            r_stat_hi <= n_stat_hi;
            r_status  <= n_status;
            r_crc     <= n_crc;
            r_matched <= n_matched;
        end
    end

    // check mode is sampled with the ninth byte
    assign o_push              = accept && (pos == fsfd_pkg::POS_LAST);
    assign o_frame.flow_word   = r_flow;
    assign o_frame.temp_word   = r_temp;
    assign o_frame.status_word = r_status;
    assign o_frame.crc_good    = r_matched || !i_crc_check_enable;

endmodule

FILE: design/fsfd_queue.sv
// Short register queue of t_frame records between front and back end.
// Uses fsfd_pkg.
module fsfd_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fsfd_pkg::t_frame i_frame,
    input  logic             i_pop,
    output fsfd_pkg::t_frame o_frame,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fsfd_pkg::t_frame   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_frame = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_frame;
        end
    end

endmodule

FILE: design/fsfd_back.sv
// Back end: four-stage scaling pipeline from t_frame record to result word.
// Flow divide by 17 uses a reciprocal multiply. Uses fsfd_pkg.
module fsfd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fsfd_pkg::t_frame                    i_frame,
    input  logic                                i_frame_valid,
    output logic                                o_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [fsfd_pkg::FLOW_W-1:0]  o_flow_milli,
    output logic signed [fsfd_pkg::TEMP_W-1:0]  o_temp_milli,
    output logic signed [fsfd_pkg::WORD_W-1:0]  o_status_word,
    output logic                                o_crc_good
);

    localparam int SUM_W  = fsfd_pkg::SUM_W;
    localparam int MAG_W  = fsfd_pkg::MAG_W;
    localparam int PROD_W = fsfd_pkg::PROD_W;
    localparam int Q_W    = PROD_W - fsfd_pkg::DIV_SHIFT;
    localparam int TEMP_W = fsfd_pkg::TEMP_W;
    localparam int WORD_W = fsfd_pkg::WORD_W;
    localparam int FLOW_W = fsfd_pkg::FLOW_W;

    logic                 en;
    logic                 r_v1, r_v2, r_v3, r_v4;

    // per-stage payload
    logic [WORD_W-1:0]    r1_abs;
    logic                 r1_neg, r2_neg, r3_neg;
    logic [TEMP_W-1:0]    r1_temp, r2_temp, r3_temp;
    logic [WORD_W-1:0]    r1_stat, r2_stat, r3_stat;
    logic                 r1_crc, r2_crc, r3_crc;
    logic [MAG_W-1:0]     r2_mag;
    logic [PROD_W-1:0]    r3_prod;
    logic [FLOW_W-1:0]    r4_flow;
    logic [TEMP_W-1:0]    r4_temp;
    logic [WORD_W-1:0]    r4_stat;
    logic                 r4_crc;

    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     sum_abs;
    logic [TEMP_W-1:0]    temp_ext;
    logic [Q_W-1:0]       quot;

    // whole pipe moves together; stalls only when the result is held
    assign en    = !r_v4 || i_out_ready;
    assign o_pop = en && i_frame_valid;

    assign sum      = {{(SUM_W - WORD_W){i_frame.flow_word[WORD_W-1]}}, i_frame.flow_word}
                      + fsfd_pkg::FLOW_OFFSET;
    assign sum_abs  = sum[SUM_W-1] ? (~sum + SUM_W'(1)) : sum;
    assign temp_ext = {{(TEMP_W - WORD_W){i_frame.temp_word[WORD_W-1]}}, i_frame.temp_word};
    assign quot     = r3_prod[PROD_W-1:fsfd_pkg::DIV_SHIFT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_frame_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: offset, magnitude, temp * 5
            r1_abs  <= sum_abs[WORD_W-1:0];
            r1_neg  <= sum[SUM_W-1];
            r1_temp <= temp_ext + (temp_ext << 2);
            r1_stat <= i_frame.status_word;
            r1_crc  <= i_frame.crc_good;
            // stage 2: times 100
            r2_mag  <= {{(MAG_W - WORD_W){1'b0}}, r1_abs} * fsfd_pkg::FLOW_SCALE;
            r2_neg  <= r1_neg;
            r2_temp <= r1_temp;
            r2_stat <= r1_stat;
            r2_crc  <= r1_crc;
            // stage 3: reciprocal of 17
            r3_prod <= {{MAG_W{1'b0}}, r2_mag} * {{MAG_W{1'b0}}, fsfd_pkg::DIV_RECIP};
            r3_neg  <= r2_neg;
            r3_temp <= r2_temp;
            r3_stat <= r2_stat;
            r3_crc  <= r2_crc;
            // stage 4: restore sign (truncation toward zero)
            r4_flow <= r3_neg ? (~{1'b0, quot} + FLOW_W'(1)) : {1'b0, quot};
            r4_temp <= r3_temp;
            r4_stat <= r3_stat;
            r4_crc  <= r3_crc;
        end
    end

    assign o_out_valid   = r_v4;
    assign o_flow_milli  = r4_flow;
    assign o_temp_milli  = r4_temp;
    assign o_status_word = r4_stat;
    assign o_crc_good    = r4_crc;

endmodule

FILE: design/fsfd_checker.sv
// Port-level checker for the flow sensor frame decoder, bound to the top level.
// Depends on assert_macros.svh and fsfd_pkg.
`include "assert_macros.svh"

module fsfd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [fsfd_pkg::FLOW_W-1:0]  o_flow_milli,
    input  logic signed [fsfd_pkg::TEMP_W-1:0]  o_temp_milli
);

    // stalled result word holds
    `ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_flow_milli) && $stable(o_temp_milli))

    // reset empties the pipe and the queue
    `ASSERT_NEXT(a_rst_out_idle, i_clk, 1'b0, !i_rst_n, !o_out_valid)
    `ASSERT_NEXT(a_rst_in_ready, i_clk, 1'b0, !i_rst_n, o_in_ready)

    // scaled values stay inside what any raw word can produce
    `ASSERT_IMPL(a_out_range, i_clk, !i_rst_n, o_out_valid, (o_flow_milli >= -20'sd48188) && (o_flow_milli <= 20'sd337311) && (o_temp_milli >= -19'sd163840) && (o_temp_milli <= 19'sd163835))

endmodule

bind flow_sensor_frame_decoder_top fsfd_checker u_fsfd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_flow_milli (o_flow_milli),
    .o_temp_milli (o_temp_milli)
);
